>>> rtl/sdx_pkg.sv
// Package for the Soundex-style name encoder: widths, group codes and the
// character-to-group lookup. Has no dependencies.

package sdx_pkg;

    localparam int CHAR_W       = 8;
    localparam int GROUP_W      = 3;
    localparam int HELD_SLOTS   = 3;
    localparam int COUNT_W      = 2;
    localparam int CODE_DIGITS_DEFAULT = 3;

    // Output tdata: lead letter, then three digits, padded to whole bytes.
    localparam int RESULT_BITS  = CHAR_W + HELD_SLOTS * GROUP_W;
    localparam int M_TDATA_W    = ((RESULT_BITS + 7) / 8) * 8;

    typedef logic [GROUP_W-1:0] group_t;

    localparam group_t GROUP_IGNORE = 3'd0;
    localparam group_t GROUP_LABIAL = 3'd1;
    localparam group_t GROUP_GUTTER = 3'd2;
    localparam group_t GROUP_DENTAL = 3'd3;
    localparam group_t GROUP_LATERAL = 3'd4;
    localparam group_t GROUP_NASAL  = 3'd5;
    localparam group_t GROUP_RHOTIC = 3'd6;
    localparam group_t GROUP_SEPARATOR = 3'd7;
    localparam group_t GROUP_NONE   = 3'd0;

    // Groups 1 to 6 for consonants, the separator code for vowel-like
    // letters, and the ignore code for anything else.
    function automatic group_t group_of(input logic [CHAR_W-1:0] c);
        group_t g;
        unique case (c)
            "B", "F", "P", "V":                     g = GROUP_LABIAL;
            "C", "G", "J", "K", "Q", "S", "X", "Z": g = GROUP_GUTTER;
            "D", "T":                               g = GROUP_DENTAL;
            "L":                                    g = GROUP_LATERAL;
            "M", "N":                               g = GROUP_NASAL;
            "R":                                    g = GROUP_RHOTIC;
            "A", "E", "I", "O", "U", "Y", "W", "H": g = GROUP_SEPARATOR;
            default:                                g = GROUP_IGNORE;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/soundex_encoder.sv
// Soundex-style name encoder, top level. Takes one character per transaction
// and gives one four-symbol code per name. Depends on sdx_pkg.
//
// Usage. Characters of a name arrive on the slave stream: s_axis_tdata holds
// the character and s_axis_tlast marks the final character of the name.
// One result transaction per name leaves on the master stream once the final
// character has been taken: the lead letter in bits 7:0 and the three group
// digits above it, 0 where the code is padded.
// The final character passes through the input register, then the output
// register, which offers its result. Throughput: one character per cycle,
// except while a final character waits on a stalled result. The input
// register, the group lookup and the digit update form one short stage; the
// per-name state loop (previous group, digit count) closes within that
// stage.
// When the receiver stalls, the result waits in the output register and the
// block still takes characters; only a final character that would overwrite
// a waiting result is held in the input register, and s_axis_tready then
// falls until the result is taken.
// Reset (aresetn low, synchronous) empties both registers and returns the
// per-name state to the start of a name. Nothing carries over between names.

module soundex_encoder
    import sdx_pkg::*;
#(
    parameter int CODE_DIGITS = CODE_DIGITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Slave stream: tdata = letter [7:0]; tlast = end_of_name.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CHAR_W-1:0]    s_axis_tdata,
    input  logic                 s_axis_tlast,
    // Master stream: tdata = lead_letter [7:0], digit_one [10:8],
    // digit_two [13:11], digit_three [16:14], zeros above.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Digit positions beyond the held slots are never recorded.
    localparam int LIMIT_INT = (CODE_DIGITS < HELD_SLOTS) ? CODE_DIGITS : HELD_SLOTS;
    localparam logic [COUNT_W-1:0] DIGIT_LIMIT = COUNT_W'(LIMIT_INT);

    // Input register.
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_letter_reg;
    logic              in_last_reg;

    // Per-name state.
    logic               at_start_reg,        at_start_next;
    group_t             previous_group_reg,  previous_group_next;
    logic [COUNT_W-1:0] digits_written_reg,  digits_written_next;
    logic [CHAR_W-1:0]  held_letter_reg,     held_letter_next;
    group_t             held_digits_reg  [HELD_SLOTS];
    group_t             held_digits_next [HELD_SLOTS];

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic   advance;
    logic   load_result;
    group_t group_code;

    // A character in the input register moves on unless it completes a
    // name while the previous result is still waiting.
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign load_result   = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    assign group_code = group_of(in_letter_reg);

    always_comb begin
        at_start_next       = at_start_reg;
        previous_group_next = previous_group_reg;
        digits_written_next = digits_written_reg;
        held_letter_next    = held_letter_reg;
        for (int i = 0; i < HELD_SLOTS; i++) begin
            held_digits_next[i] = held_digits_reg[i];
        end

        if (at_start_reg) begin
            held_letter_next    = in_letter_reg;
            previous_group_next = (group_code == GROUP_SEPARATOR) ? GROUP_NONE : group_code;
            at_start_next       = 1'b0;
        end else if (digits_written_reg < DIGIT_LIMIT) begin
            if (group_code == GROUP_SEPARATOR) begin
                previous_group_next = GROUP_NONE;
            end else if (group_code != GROUP_IGNORE) begin
                if (group_code != previous_group_reg) begin
                    for (int i = 0; i < HELD_SLOTS; i++) begin
                        if (digits_written_reg == COUNT_W'(i)) begin
                            held_digits_next[i] = group_code;
                        end
                    end
                    digits_written_next = digits_written_reg + COUNT_W'(1);
                end
                previous_group_next = group_code;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_result) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_letter_reg <= s_axis_tdata;
            in_last_reg   <= s_axis_tlast;
        end
    end

    // At the end of a name the state returns to its starting values.
    always_ff @(posedge aclk) begin
        if (!aresetn || load_result) begin
            at_start_reg       <= 1'b1;
            previous_group_reg <= GROUP_NONE;
            digits_written_reg <= '0;
            held_letter_reg    <= '0;
            for (int i = 0; i < HELD_SLOTS; i++) begin
                held_digits_reg[i] <= GROUP_NONE;
            end
        end else if (advance) begin
            at_start_reg       <= at_start_next;
            previous_group_reg <= previous_group_next;
            digits_written_reg <= digits_written_next;
            held_letter_reg    <= held_letter_next;
            for (int i = 0; i < HELD_SLOTS; i++) begin
                held_digits_reg[i] <= held_digits_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (load_result) begin
            out_data_reg <= M_TDATA_W'({held_digits_next[2], held_digits_next[1],
                                        held_digits_next[0], held_letter_next});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/sdx_checker.sv
// Port-level checks for the Soundex-style name encoder, and the bind that
// attaches them to soundex_encoder. Depends on sdx_pkg.

module sdx_checker
    import sdx_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tlast,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic s_last_taken;
    assign s_last_taken = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A result appearing from empty comes from a final character taken through the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_last_taken, 2))
        else $error("result without a completed name");

    // Digits fill from the first position: no gap before a recorded digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[13:11] == 3'd0 || m_axis_tdata[10:8] != 3'd0)
                       && (m_axis_tdata[16:14] == 3'd0 || m_axis_tdata[13:11] != 3'd0))
        else $error("digit recorded after padding");

    // Group digits never carry the separator code, and padding bits stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[10:8] != GROUP_SEPARATOR
                       && m_axis_tdata[13:11] != GROUP_SEPARATOR
                       && m_axis_tdata[16:14] != GROUP_SEPARATOR
                       && m_axis_tdata[M_TDATA_W-1:RESULT_BITS] == '0)
        else $error("malformed result digits");

endmodule

bind soundex_encoder sdx_checker u_sdx_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
